// ----- hw/rtl/nlt8_pkg.sv -----
// Shared types and constants for the nearest-light top-k selector.
// No dependencies.
package nlt8_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = 25;
  localparam int DIST_BITS  = 52;
  localparam int DOT_BITS   = 52;
  localparam int DIVD_BITS  = 60;

  localparam logic [2:0] REG_CAMERA_X  = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y  = 3'd1;
  localparam logic [2:0] REG_CAMERA_Z  = 3'd2;
  localparam logic [2:0] REG_FORWARD_X = 3'd3;
  localparam logic [2:0] REG_FORWARD_Y = 3'd4;
  localparam logic [2:0] REG_FORWARD_Z = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CHK,
    ST_DIV,
    ST_INS,
    ST_EMIT
  } state_t;

endpackage

// ----- hw/rtl/nearest_light_top8_select.sv -----
// Nearest-light top-k selector, top level.
// Once a list_end request is taken, slot 0 is offered after MUL, SUM, CHK, the bit-serial
// divide and INS; CHK skips the divide when none is needed, and an inactive light goes
// from SUM straight to the output. No new request is taken until the last is through;
// list end then holds the input while the eight results are emitted, plus any output stall.
// Reset (rst, synchronous): chain empty, camera 0, forward (0,0,256). Uses nlt8_pkg/div/cell.
module nearest_light_top8_select import nlt8_pkg::*; #(
  parameter int SELECT_COUNT = 8,
  parameter int ID_BITS      = 10,
  parameter int KEY_BITS     = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] light_x,
  input  logic signed [COORD_BITS-1:0] light_y,
  input  logic signed [COORD_BITS-1:0] light_z,
  input  logic                         light_active,
  input  logic [ID_BITS-1:0]           light_id,
  input  logic                         list_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   slot,
  output logic [ID_BITS-1:0]           chosen_id,
  output logic                         use_default,
  output logic                         slot_last
);

  localparam int SB = (SELECT_COUNT > 1) ? $clog2(SELECT_COUNT) : 1;
  localparam logic [KEY_BITS-1:0] KeyMax = '1;

  logic signed [COORD_BITS-1:0] cam_x, cam_y, cam_z, fwd_x, fwd_y, fwd_z;
  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0; cam_y <= '0; cam_z <= '0;
      fwd_x <= '0; fwd_y <= '0; fwd_z <= COORD_BITS'(256);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CAMERA_X:  cam_x <= pwdata[COORD_BITS-1:0];
        REG_CAMERA_Y:  cam_y <= pwdata[COORD_BITS-1:0];
        REG_CAMERA_Z:  cam_z <= pwdata[COORD_BITS-1:0];
        REG_FORWARD_X: fwd_x <= pwdata[COORD_BITS-1:0];
        REG_FORWARD_Y: fwd_y <= pwdata[COORD_BITS-1:0];
        REG_FORWARD_Z: fwd_z <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAMERA_X:  prdata = {8'd0, cam_x};
      REG_CAMERA_Y:  prdata = {8'd0, cam_y};
      REG_CAMERA_Z:  prdata = {8'd0, cam_z};
      REG_FORWARD_X: prdata = {8'd0, fwd_x};
      REG_FORWARD_Y: prdata = {8'd0, fwd_y};
      REG_FORWARD_Z: prdata = {8'd0, fwd_z};
      default:       prdata = '0;
    endcase
  end

  state_t state, state_next;
  logic signed [DIFF_BITS-1:0] dx, dy, dz;
  logic signed [2*DIFF_BITS-1:0] sq_x, sq_y, sq_z;
  logic signed [DIFF_BITS+COORD_BITS-1:0] pr_x, pr_y, pr_z;
  logic [DIST_BITS-1:0] dist_sq;
  logic signed [DOT_BITS-1:0] dot;
  logic [ID_BITS-1:0] req_id;
  logic req_end, req_active;
  logic [KEY_BITS-1:0] new_key;
  logic new_behind;
  logic [SB-1:0] emit_cnt;
  logic div_start, div_done;
  logic [KEY_BITS-1:0] div_q;
  logic [DOT_BITS-1:0] mag;

  assign in_ready = (state == ST_IDLE);
  assign mag = dot[DOT_BITS-1] ? DOT_BITS'(-dot) : DOT_BITS'(dot);

  // ST_CHK sees the sums registered at the end of ST_SUM
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM: begin
        if (!req_active) state_next = req_end ? ST_EMIT : ST_IDLE;
        else state_next = ST_CHK;
      end
      ST_CHK: begin
        if (dist_sq == '0 || dot == '0) state_next = ST_INS;
        else begin
          div_start = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_next = ST_INS;
      ST_INS:  state_next = req_end ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_ready && emit_cnt == SB'(SELECT_COUNT - 1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      emit_cnt <= '0;
    end else begin
      state <= state_next;
      if (state_next != ST_EMIT) emit_cnt <= '0;
      else if (state == ST_EMIT && out_ready) emit_cnt <= emit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      dx <= DIFF_BITS'(light_x) - DIFF_BITS'(cam_x);
      dy <= DIFF_BITS'(light_y) - DIFF_BITS'(cam_y);
      dz <= DIFF_BITS'(light_z) - DIFF_BITS'(cam_z);
      req_id <= light_id;
      req_end <= list_end;
      req_active <= light_active;
    end
    if (state == ST_MUL) begin
      sq_x <= dx * dx; sq_y <= dy * dy; sq_z <= dz * dz;
      pr_x <= dx * fwd_x; pr_y <= dy * fwd_y; pr_z <= dz * fwd_z;
    end
    if (state == ST_SUM) begin
      dist_sq <= DIST_BITS'(sq_x) + DIST_BITS'(sq_y) + DIST_BITS'(sq_z);
      dot     <= DOT_BITS'(pr_x) + DOT_BITS'(pr_y) + DOT_BITS'(pr_z);
    end
  end

  nlt8_div #(.KEY_BITS(KEY_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({dist_sq, 8'd0}), .divisor(mag),
    .done(div_done), .quot(div_q)
  );

  always_comb begin
    if (dist_sq == '0) begin
      new_key = '0; new_behind = 1'b0;
    end else if (dot == '0) begin
      new_key = KeyMax; new_behind = 1'b0;
    end else begin
      new_key = div_q; new_behind = dot[DOT_BITS-1];
    end
  end

  logic ins, shift, clear;

  assign ins   = (state == ST_INS);
  assign shift = (state == ST_EMIT) && out_ready;
  assign clear = 1'b0;

  logic [SELECT_COUNT-1:0] q_take, q_valid, q_behind;
  logic [ID_BITS-1:0]  q_id [SELECT_COUNT];
  logic [KEY_BITS-1:0] q_key [SELECT_COUNT];

  genvar g;
  generate
    for (g = 0; g < SELECT_COUNT; g++) begin : g_cell
      nlt8_cell #(.ID_BITS(ID_BITS), .KEY_BITS(KEY_BITS)) u_cell (
        .clk(clk), .rst(rst), .clear(clear), .ins(ins), .shift(shift),
        .new_id(req_id), .new_key(new_key), .new_behind(new_behind),
        .prev_take(g == 0 ? 1'b0 : q_take[(g == 0) ? 0 : g-1]),
        .prev_valid(g == 0 ? 1'b0 : q_valid[(g == 0) ? 0 : g-1]),
        .prev_id(q_id[(g == 0) ? 0 : g-1]),
        .prev_key(q_key[(g == 0) ? 0 : g-1]),
        .prev_behind(g == 0 ? 1'b0 : q_behind[(g == 0) ? 0 : g-1]),
        .up_valid(g == SELECT_COUNT-1 ? 1'b0 : q_valid[(g == SELECT_COUNT-1) ? g : g+1]),
        .up_id(g == SELECT_COUNT-1 ? '0 : q_id[(g == SELECT_COUNT-1) ? g : g+1]),
        .take(q_take[g]), .valid(q_valid[g]), .id(q_id[g]),
        .key(q_key[g]), .behind(q_behind[g])
      );
    end
  endgenerate

  assign out_valid   = (state == ST_EMIT);
  assign slot        = 3'(emit_cnt);
  assign chosen_id   = q_valid[0] ? q_id[0] : '0;
  assign use_default = !q_valid[0];
  assign slot_last   = (emit_cnt == SB'(SELECT_COUNT - 1));

endmodule

// ----- hw/rtl/nlt8_cell.sv -----
// One ranking cell: holds a light and passes displaced entries to its neighbor.
// Depends on nlt8_pkg.
module nlt8_cell import nlt8_pkg::*; #(
  parameter int ID_BITS  = 10,
  parameter int KEY_BITS = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                ins,
  input  logic                shift,
  input  logic [ID_BITS-1:0]  new_id,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic                new_behind,
  input  logic                prev_take,
  input  logic                prev_valid,
  input  logic [ID_BITS-1:0]  prev_id,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic                prev_behind,
  input  logic                up_valid,
  input  logic [ID_BITS-1:0]  up_id,
  output logic                take,
  output logic                valid,
  output logic [ID_BITS-1:0]  id,
  output logic [KEY_BITS-1:0] key,
  output logic                behind
);

  always_comb begin
    if (!valid) take = 1'b1;
    else if (new_behind != behind) take = !new_behind;
    else if (new_behind) take = 1'b1;
    else take = (new_key <= key);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      // output drain: move toward slot 0
      valid <= up_valid;
      id    <= up_id;
    end else if (ins && take) begin
      if (prev_take) begin
        valid  <= prev_valid;
        id     <= prev_id;
        key    <= prev_key;
        behind <= prev_behind;
      end else begin
        valid  <= 1'b1;
        id     <= new_id;
        key    <= new_key;
        behind <= new_behind;
      end
    end
  end

endmodule

// ----- hw/rtl/nlt8_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating key.
// Depends on nlt8_pkg.
module nlt8_div import nlt8_pkg::*; #(
  parameter int KEY_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIVD_BITS-1:0] dividend,
  input  logic [DOT_BITS-1:0]  divisor,
  output logic                 done,
  output logic [KEY_BITS-1:0]  quot
);

  localparam int CNT_BITS = $clog2(DIVD_BITS + 1);
  localparam logic [KEY_BITS-1:0] KeyMax = '1;

  logic [DIVD_BITS-1:0] q;
  logic [DOT_BITS:0]    rem;
  logic [DOT_BITS-1:0]  dvs;
  logic [CNT_BITS-1:0]  cnt;
  logic                 busy;
  logic [DOT_BITS:0]    trial;

  assign trial = {rem[DOT_BITS-1:0], q[DIVD_BITS-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CNT_BITS'(DIVD_BITS);
      end else if (busy) begin
        if (!trial[DOT_BITS]) begin
          rem <= trial;
          q   <= {q[DIVD_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[DOT_BITS-1:0], q[DIVD_BITS-1]};
          q   <= {q[DIVD_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  generate
    if (KEY_BITS >= DIVD_BITS) begin : g_wide
      assign quot = KEY_BITS'(q);
    end else begin : g_sat
      assign quot = (|q[DIVD_BITS-1:KEY_BITS]) ? KeyMax : q[KEY_BITS-1:0];
    end
  endgenerate

endmodule

// ----- sim/nearest_light_top8_select_test.sv -----
// Testbench for nearest_light_top8_select: ranks streamed lights and checks the eight-slot results.
// It predicts each ranking in the testbench and programs the camera and forward vector over APB.
// Depends on nlt8_pkg and the RTL of nearest_light_top8_select.
`timescale 1ns / 100ps

module nearest_light_top8_select_test import nlt8_pkg::*;;

  localparam int SLOTS = 8;
  localparam longint unsigned KEY_MAX = (64'd1 << 48) - 64'd1;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = -24'sh800000;

  typedef struct {
    logic signed [23:0] x, y, z;
    logic       active;
    logic [9:0] id;
    logic       last;
    logic       all_default; // expected slots typed in: every slot default
  } light_row_t;

  typedef struct {
    logic [2:0] slot;
    logic [9:0] id;
    logic       dflt;
    logic       last;
  } slot_res_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic signed [23:0] light_x, light_y, light_z;
  logic light_active, list_end;
  logic [9:0] light_id;
  logic out_valid, out_ready;
  logic [2:0] slot;
  logic [9:0] chosen_id;
  logic use_default, slot_last;

  nearest_light_top8_select dut (.*);

  // predictor state
  logic signed [23:0] cam_x, cam_y, cam_z, fwd_x, fwd_y, fwd_z;
  logic [9:0]            chain_id    [SLOTS];
  longint unsigned       chain_key   [SLOTS];
  logic                  chain_behind[SLOTS];
  logic                  chain_valid [SLOTS];
  slot_res_t             slots_due[$];

  int errors = 0;
  int lists_sent = 0;
  int slots_seen = 0;
  int burst_left = 0;
  bit hold_req = 0;

  light_row_t dir_rows [17] = '{
    '{24'sd0, 24'sd0, 24'sd0, 1'b0, 10'd0, 1'b1, 1'b1},
    '{24'sd0, 24'sd0, 24'sd0, 1'b1, 10'd1, 1'b0, 1'b0},
    '{24'sd0, 24'sd0, -24'sd256, 1'b1, 10'd2, 1'b0, 1'b0},
    '{24'sd256, 24'sd0, 24'sd0, 1'b1, 10'd3, 1'b0, 1'b0},
    '{24'sd0, 24'sd0, 24'sd256, 1'b1, 10'd4, 1'b0, 1'b0},
    '{24'sd0, 24'sd0, 24'sd256, 1'b1, 10'd5, 1'b0, 1'b0},
    '{24'sd0, 24'sd0, -24'sd512, 1'b1, 10'd6, 1'b0, 1'b0},
    '{CMAX, CMAX, CMAX, 1'b1, 10'd1023, 1'b0, 1'b0},
    '{CMIN, CMIN, CMIN, 1'b1, 10'd7, 1'b0, 1'b0},
    '{24'sd512, 24'sd512, 24'sd512, 1'b0, 10'd1023, 1'b0, 1'b0},
    '{24'sd100, -24'sd100, 24'sd1000, 1'b1, 10'd9, 1'b0, 1'b0},
    '{24'sd0, 24'sd0, 24'sd1, 1'b1, 10'd10, 1'b0, 1'b0},
    '{24'sd0, 24'sd0, CMAX, 1'b1, 10'd11, 1'b1, 1'b0},
    '{CMIN, 24'sd0, 24'sd0, 1'b1, 10'd0, 1'b0, 1'b0},
    '{24'sd0, CMAX, 24'sd0, 1'b1, 10'd1023, 1'b0, 1'b0},
    '{24'sd0, 24'sd0, 24'sd0, 1'b1, 10'd12, 1'b1, 1'b0},
    '{24'sd0, 24'sd0, 24'sd0, 1'b0, 10'd13, 1'b1, 1'b1}
  };

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_chain();
    for (int i = 0; i < SLOTS; i++) begin
      chain_id[i] = '0;
      chain_key[i] = 0;
      chain_behind[i] = 0;
      chain_valid[i] = 0;
    end
  endfunction

  function automatic void due_add(slot_res_t s);
    slots_due = {slots_due, s};
  endfunction

  function automatic bit beats_cell(longint unsigned key, bit behind, int i);
    if (!chain_valid[i]) return 1;
    if (behind != chain_behind[i]) return !behind;
    if (behind) return 1;
    return key <= chain_key[i];
  endfunction

  // rank one accepted light; queue the slot results on list end
  function automatic void rank_light(light_row_t r);
    longint dx, dy, dz, p;
    longint unsigned d, mag, key;
    bit behind;
    int pos;
    if (r.active) begin
      dx = longint'(r.x) - longint'(cam_x);
      dy = longint'(r.y) - longint'(cam_y);
      dz = longint'(r.z) - longint'(cam_z);
      p = dx * longint'(fwd_x) + dy * longint'(fwd_y) + dz * longint'(fwd_z);
      d = longint'(dx * dx + dy * dy + dz * dz);
      behind = 0;
      if (d == 0) key = 0;
      else if (p == 0) key = KEY_MAX;
      else begin
        mag = (p < 0) ? longint'(-p) : longint'(p);
        key = (d << 8) / mag;
        if (key > KEY_MAX) key = KEY_MAX;
        behind = p < 0;
      end
      pos = 0;
      while (pos < SLOTS && !beats_cell(key, behind, pos)) pos++;
      if (pos < SLOTS) begin
        for (int i = SLOTS - 1; i > pos; i--) begin
          chain_id[i] = chain_id[i-1];
          chain_key[i] = chain_key[i-1];
          chain_behind[i] = chain_behind[i-1];
          chain_valid[i] = chain_valid[i-1];
        end
        chain_id[pos] = r.id;
        chain_key[pos] = key;
        chain_behind[pos] = behind;
        chain_valid[pos] = 1;
      end
    end
    if (r.last) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (r.all_default)
          due_add('{3'(i), 10'd0, 1'b1, i == SLOTS - 1});
        else
          due_add('{3'(i), chain_valid[i] ? chain_id[i] : 10'd0,
                    !chain_valid[i], i == SLOTS - 1});
      end
      clear_chain();
    end
  endfunction

  task automatic reg_write(logic [2:0] idx, logic signed [23:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= {8'($urandom), val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0;
    case (idx)
      REG_CAMERA_X:  cam_x = val;
      REG_CAMERA_Y:  cam_y = val;
      REG_CAMERA_Z:  cam_z = val;
      REG_FORWARD_X: fwd_x = val;
      REG_FORWARD_Y: fwd_y = val;
      REG_FORWARD_Z: fwd_z = val;
      default: ;
    endcase
  endtask

  task automatic set_view(logic signed [23:0] cx, cy, cz, fx, fy, fz);
    reg_write(REG_CAMERA_X, cx);
    reg_write(REG_CAMERA_Y, cy);
    reg_write(REG_CAMERA_Z, cz);
    reg_write(REG_FORWARD_X, fx);
    reg_write(REG_FORWARD_Y, fy);
    reg_write(REG_FORWARD_Z, fz);
  endtask

  // offer one light request, bursty, and wait for it to be taken
  task automatic send_light(light_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1;
    light_x <= r.x; light_y <= r.y; light_z <= r.z;
    light_active <= r.active; light_id <= r.id; list_end <= r.last;
    do @(posedge clk); while (!in_ready);
    rank_light(r);
    if (r.last) lists_sent++;
  endtask

  task automatic settle();
    in_valid <= 0;
    burst_left = 0;
    while (slots_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_coord(logic signed [23:0] base);
    case ($urandom_range(0, 7))
      0: return CMAX;
      1: return CMIN;
      2, 3: return 24'($urandom);
      default: return base + 24'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // receiver: own ready pattern plus one long hold-off on request
  initial begin
    int hold_cnt, mode_cnt, mode;
    hold_cnt = 0; mode_cnt = 0; mode = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (mode_cnt == 0) begin
        mode = $urandom_range(0, 2);
        mode_cnt = $urandom_range(20, 120);
      end
      mode_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
        out_ready <= 0;
      end else begin
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= $urandom_range(0, 9) != 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    slot_res_t want;
    if (!rst && out_valid && out_ready) begin
      slots_seen++;
      if (slots_due.size() == 0) begin
        $error("unexpected slot result: slot %0d id %0d", slot, chosen_id);
        errors++;
      end else begin
        want = slots_due.pop_front();
        if (slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot); errors++;
        end
        if (chosen_id !== want.id) begin
          $error("chosen_id: expected %0d, got %0d", want.id, chosen_id); errors++;
        end
        if (use_default !== want.dflt) begin
          $error("use_default: expected %0d, got %0d", want.dflt, use_default); errors++;
        end
        if (slot_last !== want.last) begin
          $error("slot_last: expected %0d, got %0d", want.last, slot_last); errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    light_row_t r;
    int n, list_len;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; light_x = '0; light_y = '0; light_z = '0;
    light_active = 0; light_id = '0; list_end = 0;
    cam_x = 0; cam_y = 0; cam_z = 0; fwd_x = 0; fwd_y = 0; fwd_z = 24'sd256;
    clear_chain();
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed table under reset view
    foreach (dir_rows[i]) send_light(dir_rows[i]);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_view(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        1: set_view(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        2: set_view(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1);
        3: set_view(24'sd1000, -24'sd1000, 24'sd0, 24'sd256, 24'sd256, 24'sd256);
        default: set_view(24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom), 24'($urandom));
      endcase
      if (ph == 4) begin
        reg_write(REG_SPARE_6, 24'($urandom));
        reg_write(REG_SPARE_7, 24'($urandom));
      end
      if (ph == 5) hold_req = 1;
      n = 0;
      while (n < 16) begin
        list_len = $urandom_range(0, 4) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 8);
        for (int k = 0; k < list_len; k++) begin
          r.x = pick_coord(cam_x);
          r.y = pick_coord(cam_y);
          r.z = pick_coord(cam_z);
          r.active = $urandom_range(0, 4) != 0;
          r.id = $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 7)) : 10'($urandom);
          r.last = (k == list_len - 1) || (n + k >= 15);
          r.all_default = 0;
          send_light(r);
          if (r.last) begin
            n += k + 1;
            break;
          end
        end
      end
      settle();
    end

    $display("covered %0d light lists over 7 view settings, %0d slot results checked",
             lists_sent, slots_seen);
    if (errors == 0 && slots_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/nlt8_pkg.sv
hw/rtl/nlt8_cell.sv
hw/rtl/nlt8_div.sv
hw/rtl/nearest_light_top8_select.sv
sim/nearest_light_top8_select_test.sv
